/* sv/nrmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_pkg: shared types, constants and helpers
// Character class record, RMC header bytes, time field positions, mod-24.
// ----------------------------------------------------------------------------
package nrmc_pkg;

	// ASCII codes the block cares about
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;

	// sentence positions
	localparam logic [7:0] HDR_LEN   = 8'd6;
	localparam logic [7:0] POS_HOUR_T = 8'd7;
	localparam logic [7:0] POS_HOUR_U = 8'd8;
	localparam logic [7:0] POS_MIN_T  = 8'd9;
	localparam logic [7:0] POS_MIN_U  = 8'd10;
	localparam logic [7:0] POS_SEC_T  = 8'd11;
	localparam logic [7:0] POS_SEC_U  = 8'd12;
	localparam logic [7:0] POS_MAX    = 8'd255;

	localparam logic [4:0] OFFSET_RESET = 5'd8;

	// one classified input byte
	typedef struct packed {
		logic [7:0] ch;
		logic       ws;
		logic       star;
		logic       hex_ok;
		logic [3:0] hex_val;
		logic [3:0] dec_val;
	} nrmc_class_t;

	// expected header byte at positions 0..5
	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = CH_DOLLAR;
			3'd1: c = CH_G;
			3'd2: c = CH_P;
			3'd3: c = CH_R;
			3'd4: c = CH_M;
			3'd5: c = CH_C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// v < 192: three compare/subtract steps leave v mod 24
	function automatic logic [4:0] mod24(input logic [7:0] v);
		logic [7:0] t;
		t = v;
		if (t >= 8'd96) t = t - 8'd96;
		if (t >= 8'd48) t = t - 8'd48;
		if (t >= 8'd24) t = t - 8'd24;
		return t[4:0];
	endfunction

	// digit * 10 as shifts and one add
	function automatic logic [6:0] times10(input logic [3:0] d);
		return {d, 3'b000} + {2'b00, d, 1'b0};
	endfunction

endpackage

/* sv/nrmc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_front: input acceptance and character classification
// Decodes whitespace, '*', hex and decimal digits and pushes the record.
// ----------------------------------------------------------------------------
module nrmc_front
	import nrmc_pkg::*;
(
	input  logic        in_valid,
	input  logic [7:0]  char_in,
	input  logic        q_full,
	output logic        in_stall,
	output logic        push,
	output nrmc_class_t cls
);

	logic is_dec, is_uhex, is_lhex;

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	always_comb begin
		is_dec  = (char_in >= CH_0) && (char_in <= CH_9);
		is_uhex = (char_in >= CH_UA) && (char_in <= CH_UF);
		is_lhex = (char_in >= CH_LA) && (char_in <= CH_LF_HEX);

		cls.ch      = char_in;
		cls.ws      = (char_in == CH_SPACE) || (char_in == CH_TAB) ||
			(char_in == CH_CR) || (char_in == CH_LF);
		cls.star    = (char_in == CH_STAR);
		cls.hex_ok  = is_dec | is_uhex | is_lhex;
		cls.dec_val = is_dec ? char_in[3:0] : 4'd0;
		// 'A'..'F' and 'a'..'f' both have low nibble 1..6
		if (is_dec)
			cls.hex_val = char_in[3:0];
		else if (is_uhex || is_lhex)
			cls.hex_val = char_in[3:0] + 4'd9;
		else
			cls.hex_val = 4'd0;
	end

endmodule

/* sv/nrmc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_fifo: two-entry queue of classified bytes
// Decouples the classifier from the sentence engine.
// ----------------------------------------------------------------------------
module nrmc_fifo
	import nrmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  nrmc_class_t wdata,
	input  logic        pop,
	output logic        full,
	output logic        head_valid,
	output nrmc_class_t head
);

	nrmc_class_t mem_q [2];
	logic        wptr_q, rptr_q;
	logic [1:0]  count_q;

	assign full       = count_q[1];
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

/* sv/nrmc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_back: sentence engine and result register
// Tracks header, checksum and time fields; emits one result per RMC sentence that has a '*'.
// ----------------------------------------------------------------------------
module nrmc_back
	import nrmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  nrmc_class_t head,
	input  logic [4:0]  offset,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_error,
	output logic [4:0]  local_hour,
	output logic [6:0]  minute,
	output logic [6:0]  second
);

	logic [7:0] pos_q, pos_d;
	logic       hdr_q, hdr_d;
	logic       star_q, star_d;
	logic [7:0] xor_q, xor_d;
	logic [1:0] cnt_q, cnt_d;
	logic [7:0] sum_q, sum_d;
	logic       bad_q, bad_d;
	logic [6:0] hour_q, hour_d;
	logic [6:0] min_q, min_d;
	logic [6:0] sec_q, sec_d;
	logic       emit, err;
	logic [4:0] hour_res;

	// take the head once the result slot is free or draining
	assign pop = head_valid & (~out_valid | ~out_stall);

	always_comb begin
		pos_d  = pos_q;
		hdr_d  = hdr_q;
		star_d = star_q;
		xor_d  = xor_q;
		cnt_d  = cnt_q;
		sum_d  = sum_q;
		bad_d  = bad_q;
		hour_d = hour_q;
		min_d  = min_q;
		sec_d  = sec_q;
		emit   = 1'b0;
		err    = ~cnt_q[1] | bad_q | (sum_q != xor_q);
		hour_res = mod24(8'(hour_q) + 8'(offset));

		if (head.ws) begin
			emit   = hdr_q && (pos_q >= HDR_LEN) && star_q;
			pos_d  = 8'd0;
			hdr_d  = 1'b1;
			star_d = 1'b0;
			xor_d  = 8'd0;
			cnt_d  = 2'd0;
			sum_d  = 8'd0;
			bad_d  = 1'b0;
			hour_d = 7'd0;
			min_d  = 7'd0;
			sec_d  = 7'd0;
		end else begin
			if (pos_q < HDR_LEN && head.ch != hdr_char(pos_q[2:0]))
				hdr_d = 1'b0;

			unique case (pos_q)
				POS_HOUR_T: hour_d = times10(head.dec_val);
				POS_HOUR_U: hour_d = hour_q + 7'(head.dec_val);
				POS_MIN_T:  min_d  = times10(head.dec_val);
				POS_MIN_U:  min_d  = min_q + 7'(head.dec_val);
				POS_SEC_T:  sec_d  = times10(head.dec_val);
				POS_SEC_U:  sec_d  = sec_q + 7'(head.dec_val);
				default: ;
			endcase

			if (!star_q) begin
				if (head.star)
					star_d = 1'b1;
				else if (pos_q != 8'd0)
					xor_d = xor_q ^ head.ch;
			end else if (!cnt_q[1]) begin
				sum_d = {sum_q[3:0], head.hex_val};
				bad_d = bad_q | ~head.hex_ok;
				cnt_d = cnt_q + 2'd1;
			end

			if (pos_q != POS_MAX) pos_d = pos_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 8'd0;
			hdr_q     <= 1'b1;
			star_q    <= 1'b0;
			xor_q     <= 8'd0;
			cnt_q     <= 2'd0;
			sum_q     <= 8'd0;
			bad_q     <= 1'b0;
			hour_q    <= 7'd0;
			min_q     <= 7'd0;
			sec_q     <= 7'd0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				pos_q  <= pos_d;
				hdr_q  <= hdr_d;
				star_q <= star_d;
				xor_q  <= xor_d;
				cnt_q  <= cnt_d;
				sum_q  <= sum_d;
				bad_q  <= bad_d;
				hour_q <= hour_d;
				min_q  <= min_d;
				sec_q  <= sec_d;
			end
			if (pop && emit)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			is_error   <= err;
			local_hour <= err ? 5'd0 : hour_res;
			minute     <= err ? 7'd0 : min_q;
			second     <= err ? 7'd0 : sec_q;
		end
	end

`ifndef SYNTH
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_error) |-> (local_hour == 5'd0 && minute == 7'd0 &&
		second == 7'd0)) else $error("error result carries time fields");
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (local_hour < 5'd24)) else $error("local hour out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(is_error) &&
		$stable(local_hour) && $stable(minute) && $stable(second)))
		else $error("stalled result lost or changed");
`endif

endmodule

/* sv/nmea_rmc_checksum_time_core.sv */
`timescale 1ns / 1ps
// Path: an accepted byte is written into the queue, and the sentence engine takes it
//   from the queue head; an ending whitespace byte loads its result into the result register.
// Throughput: one byte per cycle while the output is not stalled; the two-entry queue and the
//   result register let input and output stall independently.
// Reset: utc_offset_hours returns to 8, queue empties, sentence state clears.
// ----------------------------------------------------------------------------
// nmea_rmc_checksum_time_core: NMEA RMC checksum check and local time
// Verifies the XOR checksum of $GPRMC sentences and reports ((hh+offset) mod 24):mm:ss.
// ----------------------------------------------------------------------------
module nmea_rmc_checksum_time_core
	import nrmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration: utc_offset_hours
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	// character transactions in
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	// result transactions out
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_error,
	output logic [4:0] local_hour,
	output logic [6:0] minute,
	output logic [6:0] second
);

	logic [4:0]  offset_q;
	logic        q_full, push, pop, head_valid;
	nrmc_class_t cls, head;

	// offset register; the user must write it only while no transaction is in flight (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			offset_q <= OFFSET_RESET;
		else if (cfg_wr_en)
			offset_q <= cfg_wr_data;
	end

	// front end: accept and classify each byte
	nrmc_front u_front (
		.in_valid (in_valid),
		.char_in  (char_in),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.cls      (cls)
	);

	// queue between classifier and sentence engine
	nrmc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wdata      (cls),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// back end: sentence state, checksum compare, time decode, result register
	nrmc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.offset     (offset_q),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_error   (is_error),
		.local_hour (local_hour),
		.minute     (minute),
		.second     (second)
	);

endmodule

/* tb/nmea_rmc_checksum_time_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_checksum_time_core_test: self-checking bench for the RMC core
// Streams character transactions that form RMC and other sentences plus noise
// through the core. A predictor tracks each sentence and queues the expected
// time result, which the result monitor compares field by field.
// ----------------------------------------------------------------------------
module nmea_rmc_checksum_time_core_test;
	import nrmc_pkg::*;

	// How the checksum tail of a built sentence is formed
	typedef enum int {
		SUM_UPPER,
		SUM_LOWER,
		SUM_WRONG,
		SUM_ONE_DIGIT,
		SUM_NO_DIGIT,
		SUM_BAD_HEX,
		SUM_EXTRA,
		SUM_ABSENT
	} sum_mode_e;

	typedef struct packed {
		logic       err;
		logic [4:0] hour;
		logic [6:0] min;
		logic [6:0] sec;
	} time_result_t;

	localparam string RMC_TAG       = "$GPRMC";
	localparam string NOT_HEX       = "GgZz,.!~:";
	localparam int    STALL_LIMIT   = 2000;  // cycles with no transaction at all
	localparam int    SETTLE_CYCLES = 8;     // lets the queue and the result register drain

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [4:0] cfg_wr_data = '0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] char_in     = '0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic       is_error;
	logic [4:0] local_hour;
	logic [6:0] minute;
	logic [6:0] second;

	nmea_rmc_checksum_time_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_in    (char_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_error   (is_error),
		.local_hour (local_hour),
		.minute     (minute),
		.second     (second)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Sentence tracker: mirrors the core's per-sentence state
	// ------------------------------------------------------------------------
	logic [4:0]   tz_offset = OFFSET_RESET;
	logic [7:0]   pos_q;
	logic         hdr_ok;
	logic         star_q;
	logic [7:0]   xor_q;
	logic [1:0]   ndig_q;
	logic [7:0]   rsum_q;
	logic         hex_bad_q;
	logic [6:0]   hour_q;
	logic [6:0]   min_q;
	logic [6:0]   sec_q;

	time_result_t pending_times[$];

	// stats and error count
	int fail_count      = 0;
	int bytes_taken     = 0;
	int times_checked   = 0;
	int errors_checked  = 0;
	int offset_writes   = 0;

	// gap control: when low, neither side idles
	bit traffic_gaps = 1'b1;

	logic [7:0] line_buf[$];

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic [6:0] digit_value(input logic [7:0] c);
		return (c >= CH_0 && c <= CH_9) ? 7'(c - CH_0) : 7'd0;
	endfunction

	task automatic clear_sentence_state();
		pos_q     = '0;
		hdr_ok    = 1'b1;
		star_q    = 1'b0;
		xor_q     = '0;
		ndig_q    = '0;
		rsum_q    = '0;
		hex_bad_q = 1'b0;
		hour_q    = '0;
		min_q     = '0;
		sec_q     = '0;
	endtask

	// Advance the tracker by one accepted character; a blank that closes a
	// qualifying RMC sentence queues one expected time result.
	task automatic track_sentence(input logic [7:0] c);
		time_result_t r;
		int           h;
		logic [3:0]   nib;
		if (is_blank(c)) begin
			if (hdr_ok && pos_q >= HDR_LEN && star_q) begin
				r = '0;
				if (ndig_q < 2'd2 || hex_bad_q || rsum_q != xor_q) begin
					r.err = 1'b1;
				end else begin
					h      = (int'(hour_q) + int'(tz_offset)) % 24;
					r.hour = 5'(h);
					r.min  = min_q;
					r.sec  = sec_q;
				end
				pending_times.push_back(r);
			end
			clear_sentence_state();
		end else begin
			if (pos_q < HDR_LEN && c != RMC_TAG[pos_q])
				hdr_ok = 1'b0;
			// time pairs: tens digit replaces, units digit adds
			case (pos_q)
				POS_HOUR_T: hour_q = digit_value(c) * 7'd10;
				POS_HOUR_U: hour_q = hour_q + digit_value(c);
				POS_MIN_T:  min_q  = digit_value(c) * 7'd10;
				POS_MIN_U:  min_q  = min_q + digit_value(c);
				POS_SEC_T:  sec_q  = digit_value(c) * 7'd10;
				POS_SEC_U:  sec_q  = sec_q + digit_value(c);
				default: ;
			endcase
			if (!star_q) begin
				if (c == CH_STAR)
					star_q = 1'b1;
				else if (pos_q >= 8'd1)
					xor_q ^= c;
			end else if (ndig_q < 2'd2) begin
				nib = '0;
				if (c >= CH_0 && c <= CH_9)
					nib = 4'(c - CH_0);
				else if (c >= CH_UA && c <= CH_UF)
					nib = 4'(c - CH_UA + 8'd10);
				else if (c >= CH_LA && c <= CH_LF_HEX)
					nib = 4'(c - CH_LA + 8'd10);
				else
					hex_bad_q = 1'b1;
				rsum_q = {rsum_q[3:0], nib};
				ndig_q = ndig_q + 2'd1;
			end
			if (pos_q != POS_MAX)
				pos_q = pos_q + 8'd1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver side
	// ------------------------------------------------------------------------

	// One character transaction; idles first now and then
	task automatic send_char(input logic [7:0] c);
		if (traffic_gaps && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= c;
		do
			@(posedge clk);
		while (in_stall);
		bytes_taken++;
		track_sentence(c);
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_char(line_buf[i]);
		line_buf.delete();
	endtask

	// Hold off input until every queued result is out, then let the tail
	// of a no-result sentence flush through the pipe.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_times.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(input logic [4:0] v);
		wait_results_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		tz_offset = v;
		offset_writes++;
	endtask

	// ------------------------------------------------------------------------
	// Sentence builders
	// ------------------------------------------------------------------------
	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// any byte that neither ends the sentence nor opens the checksum
	function automatic logic [7:0] rand_body_byte();
		logic [7:0] c;
		do begin
			if ($urandom_range(99) < 70)
				c = 8'($urandom_range(8'h21, 8'h7E));
			else
				c = 8'($urandom_range(0, 255));
		end while (is_blank(c) || c == CH_STAR);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10)
			return CH_0 + 8'(n);
		return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
	endfunction

	// Append the checksum tail and a blank to line_buf, then send it.
	// XOR covers everything after the first byte; builders keep '*' out.
	task automatic finish_sentence(input sum_mode_e mode);
		logic [7:0] sum;
		logic [7:0] bad;
		bit         lower;
		sum   = '0;
		lower = $urandom_range(1);
		for (int i = 1; i < line_buf.size(); i++)
			sum ^= line_buf[i];
		bad = NOT_HEX[$urandom_range(0, NOT_HEX.len() - 1)];
		if (mode != SUM_ABSENT)
			line_buf.push_back(CH_STAR);
		case (mode)
			SUM_UPPER, SUM_LOWER, SUM_EXTRA: begin
				line_buf.push_back(hex_char(sum[7:4], mode == SUM_LOWER || (mode == SUM_EXTRA && lower)));
				line_buf.push_back(hex_char(sum[3:0], mode == SUM_LOWER || (mode == SUM_EXTRA && lower)));
				if (mode == SUM_EXTRA)
					repeat ($urandom_range(1, 4)) line_buf.push_back(rand_body_byte());
			end
			SUM_WRONG: begin
				sum ^= 8'h01 << $urandom_range(7);
				line_buf.push_back(hex_char(sum[7:4], lower));
				line_buf.push_back(hex_char(sum[3:0], lower));
			end
			SUM_ONE_DIGIT: line_buf.push_back(hex_char(sum[7:4], lower));
			SUM_BAD_HEX: begin
				if ($urandom_range(1)) begin
					line_buf.push_back(bad);
					line_buf.push_back(hex_char(sum[3:0], lower));
				end else begin
					line_buf.push_back(hex_char(sum[7:4], lower));
					line_buf.push_back(bad);
				end
			end
			default: ;
		endcase
		line_buf.push_back(rand_blank());
		send_line();
	endtask

	// Random RMC-shaped sentence; bad_hdr >= 0 corrupts that header byte,
	// long_body pushes the position counter past saturation.
	task automatic build_rmc(input int bad_hdr, input bit long_body);
		int         tdig;
		int         nbody;
		logic [7:0] c;
		for (int i = 0; i < 6; i++) begin
			c = RMC_TAG[i];
			if (i == bad_hdr)
				c = rand_body_byte();
			line_buf.push_back(c);
		end
		line_buf.push_back(8'h2C);  // ','
		tdig = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : 6;
		for (int i = 0; i < tdig; i++) begin
			if ($urandom_range(9) == 0)
				line_buf.push_back(rand_body_byte());
			else
				line_buf.push_back(CH_0 + 8'($urandom_range(9)));
		end
		nbody = long_body ? $urandom_range(250, 270) : $urandom_range(0, 20);
		repeat (nbody) line_buf.push_back(rand_body_byte());
	endtask

	function automatic sum_mode_e rand_sum_mode();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return SUM_UPPER;
		if (r < 65)
			return SUM_LOWER;
		return sum_mode_e'($urandom_range(int'(SUM_WRONG), int'(SUM_ABSENT)));
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Which sentences produce a result at all
	task automatic test_sentence_framing();
		// back-to-back blanks of every kind
		line_buf = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_SPACE};
		send_line();
		put_str("$GPRM");
		line_buf.push_back(CH_SPACE);
		send_line();
		// full header, no star
		put_str("$GPRMC");
		line_buf.push_back(CH_LF);
		send_line();
		// bare header with a checksum: the shortest qualifying sentence
		put_str("$GPRMC");
		finish_sentence(SUM_UPPER);
		put_str("$GPGGA,123519,4807.038");
		finish_sentence(SUM_UPPER);
		put_str("$GPRMC,123519,A");
		finish_sentence(SUM_ABSENT);
	endtask

	// Every way the checksum tail can pass or fail
	task automatic test_checksum_forms();
		for (int m = int'(SUM_UPPER); m < int'(SUM_ABSENT); m++) begin
			put_str("$GPRMC,235959,A,4807.038,N");
			finish_sentence(sum_mode_e'(m));
		end
	endtask

	// Time decoding corner cases at the reset offset
	task automatic test_time_fields();
		put_str("$GPRMC,0x1y2z,V");     // non-digit time bytes count as zero
		finish_sentence(SUM_UPPER);
		put_str("$GPRMC,12");           // time cut short by the star
		finish_sentence(SUM_LOWER);
		put_str("$GPRMC,1234");
		finish_sentence(SUM_UPPER);
		put_str("$GPRMC,000000,");      // high-bit bytes in the checksum
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h80);
		line_buf.push_back(8'h7F);
		finish_sentence(SUM_UPPER);
		// past the position saturation point
		put_str("$GPRMC,010203,");
		repeat (270) line_buf.push_back(rand_body_byte());
		finish_sentence(SUM_LOWER);
	endtask

	// Offset register at its extremes, including values above 23
	task automatic test_offset_extremes();
		logic [4:0] offs[4];
		offs = '{5'd0, 5'd23, 5'd24, 5'd31};
		foreach (offs[i]) begin
			write_offset(offs[i]);
			put_str("$GPRMC,995959");
			finish_sentence(SUM_UPPER);
			put_str("$GPRMC,000000");
			finish_sentence(SUM_LOWER);
			put_str("$GPRMC,230000");
			finish_sentence(SUM_UPPER);
		end
	endtask

	// Mostly well-formed RMC traffic with random content, plus corrupted
	// headers, truncated headers and raw noise. Four phases, each at its
	// own offset; one phase runs with no gaps on either side.
	task automatic test_random_traffic();
		int         stop_at;
		int         r;
		logic [4:0] phase_off;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       phase_off = 5'd31;
				2:       phase_off = 5'd0;
				default: phase_off = 5'($urandom_range(0, 31));
			endcase
			write_offset(phase_off);
			traffic_gaps = (phase != 2);
			stop_at = bytes_taken + 190;
			while (bytes_taken < stop_at) begin
				r = $urandom_range(99);
				if (r < 75) begin
					build_rmc(-1, $urandom_range(49) == 0);
					finish_sentence(rand_sum_mode());
				end else if (r < 85) begin
					build_rmc($urandom_range(0, 5), 1'b0);
					finish_sentence(rand_sum_mode());
				end else if (r < 92) begin
					put_str(RMC_TAG.substr(0, $urandom_range(0, 4)));
					finish_sentence(rand_sum_mode());
				end else begin
					repeat ($urandom_range(1, 12))
						line_buf.push_back(8'($urandom_range(0, 255)));
					line_buf.push_back(rand_blank());
					send_line();
				end
			end
			// sender holds until the core has caught up
			if (phase == 1)
				wait_results_drained();
		end
		traffic_gaps = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Result monitor, output stall generator and watchdog
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin : check_results
		time_result_t want;
		out_stall <= traffic_gaps && ($urandom_range(99) < 10);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_times.size() == 0) begin
				$error("result with nothing expected: err=%0d %0d:%0d:%0d",
				       is_error, local_hour, minute, second);
				fail_count++;
			end else begin
				want = pending_times.pop_front();
				times_checked++;
				if (want.err)
					errors_checked++;
				if (is_error !== want.err) begin
					$error("is_error: expected %0d, got %0d", want.err, is_error);
					fail_count++;
				end
				if (local_hour !== want.hour) begin
					$error("local_hour: expected %0d, got %0d", want.hour, local_hour);
					fail_count++;
				end
				if (minute !== want.min) begin
					$error("minute: expected %0d, got %0d", want.min, minute);
					fail_count++;
				end
				if (second !== want.sec) begin
					$error("second: expected %0d, got %0d", want.sec, second);
					fail_count++;
				end
			end
		end
	end

	// any transaction on either side counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		clear_sentence_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_sentence_framing();
		test_checksum_forms();
		test_time_fields();
		test_offset_extremes();
		test_random_traffic();

		wait_results_drained();
		$display("Sent %0d characters; checked %0d time results, %0d of them flagged bad.",
		         bytes_taken, times_checked, errors_checked);
		$display("Offset register written %0d times, both range ends and above 23 included.",
		         offset_writes);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
sv/nrmc_pkg.sv
sv/nrmc_front.sv
sv/nrmc_fifo.sv
sv/nrmc_back.sv
sv/nmea_rmc_checksum_time_core.sv
tb/nmea_rmc_checksum_time_core_test.sv
